### hdl/lslf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lslf_pkg
// Shared widths, types and sequencer states of the least-squares line fitter.
// ---------------------------------------------------------------------------
package lslf_pkg;

   localparam int COORD_W     = 16;
   localparam int FRAC_W      = 16;
   localparam int OUT_W       = 32;
   localparam int POINT_CNT_W = 9;
   localparam int MAX_POINTS  = 256;

   localparam int COUNT_W = $clog2(MAX_POINTS + 1);
   localparam int LOG_W   = $clog2(MAX_POINTS);
   localparam int SUM1_W  = COORD_W + LOG_W;
   localparam int SUM2_W  = 2 * COORD_W + LOG_W;
   localparam int DEN_W   = COUNT_W + SUM2_W;

   // signed operands of the shared multiplier, one guard bit each
   localparam int MUL_A_W = ((SUM2_W > OUT_W) ? SUM2_W : OUT_W) + 1;
   localparam int MUL_B_W = ((SUM1_W > COUNT_W) ? SUM1_W : COUNT_W) + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam int T_W    = PROD_W + 1;
   localparam int FEED_W = T_W - FRAC_W;
   localparam int STEP_W = $clog2(FEED_W + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC_XY,
      ST_ACC_XX,
      ST_ACC_END,
      ST_FIT_NXX,
      ST_FIT_XX,
      ST_FIT_NXY,
      ST_FIT_XY,
      ST_FIT_MAG,
      ST_FIT_CHK,
      ST_DIV_SLOPE,
      ST_MUL_T,
      ST_FIT_T,
      ST_ICPT_GO,
      ST_DIV_ICPT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

### hdl/least_squares_line_fit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Timing: a point that is not last occupies the block for its accept plus two
//   passes through the shared multiplier; a dropped point leaves the block idle. The
//   result of a last point waits on the restoring divider (32 quotient bits for the
//   slope, 51 for the intercept) and on the multiplies and sequencing around it.
// Flow: no point is taken until the last is folded in; ready is low while a fit runs.
// Reset: synchronous, active high; clears the sums, count, mode and result valid.
// ---------------------------------------------------------------------------
// least_squares_line_fit_top
// Accumulates point sums and computes the least-squares slope and intercept.
// ---------------------------------------------------------------------------
module least_squares_line_fit_top
   import lslf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic                     csr_wr_data,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [COORD_W-1:0]       req_coord_x,
   input  wire logic [COORD_W-1:0]       req_coord_y,
   input  wire logic                     req_last_point,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [OUT_W-1:0]       rsp_slope,
   output logic signed [OUT_W-1:0]       rsp_intercept,
   output logic [POINT_CNT_W-1:0]        rsp_point_count,
   output logic                          rsp_degenerate,
   output logic                          rsp_overflowed
);

   localparam logic signed [OUT_W-1:0] S_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] S_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   // saturate a sign and magnitude to the signed output range
   function automatic logic signed [OUT_W-1:0] sat_mag(input logic neg,
                                                       input logic [FEED_W-1:0] mag);
      logic [FEED_W-1:0] pos_lim;
      logic [FEED_W-1:0] neg_lim;
      pos_lim = FEED_W'({(OUT_W-1){1'b1}});
      neg_lim = FEED_W'(1) << (OUT_W - 1);
      if (!neg) begin
         sat_mag = (mag > pos_lim) ? S_MAX : signed'(mag[OUT_W-1:0]);
      end else begin
         sat_mag = (mag > neg_lim) ? S_MIN : signed'(-mag[OUT_W-1:0]);
      end
   endfunction

   state_type state_ff, state_in;
   logic                     mode_ff, mode_in;
   logic [COUNT_W-1:0]       run_count_ff, run_count_in;
   logic [SUM1_W-1:0]        sum_first_ff, sum_first_in;
   logic [SUM1_W-1:0]        sum_second_ff, sum_second_in;
   logic [SUM2_W-1:0]        sum_product_ff, sum_product_in;
   logic [SUM2_W-1:0]        sum_square_ff, sum_square_in;
   logic                     drop_ff, drop_in;
   logic [COORD_W-1:0]       xv_ff, xv_in;
   logic [COORD_W-1:0]       yv_ff, yv_in;
   logic                     last_ff, last_in;
   logic [DEN_W-1:0]         nxx_ff, nxx_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [DEN_W-1:0]         nxy_ff, nxy_in;
   logic                     neg_ff, neg_in;
   logic [DEN_W-1:0]         mag_ff, mag_in;
   logic signed [OUT_W-1:0]  slope_u_ff, slope_u_in;
   logic signed [T_W-1:0]    t_ff, t_in;
   logic signed [OUT_W-1:0]  icpt_ff, icpt_in;
   logic                     degen_ff, degen_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]  rsp_slope_ff, rsp_slope_in;
   logic signed [OUT_W-1:0]  rsp_icpt_ff, rsp_icpt_in;
   logic [POINT_CNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                     rsp_degen_ff, rsp_degen_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic [DEN_W-1:0]          prod_low;

   div_ctrl_type              div_ctrl;
   div_stat_type              div_stat;
   logic [DEN_W-1:0]          div_rem_init;
   logic [FEED_W-1:0]         div_feed_init;
   logic [DEN_W-1:0]          div_divisor;
   logic [FEED_W-1:0]         div_quotient;

   logic [T_W-1:0]            abs_t;
   logic signed [OUT_W-1:0]   vert_slope;
   logic                      accept;
   logic                      load_rsp;

   lslf_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   lslf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .rem_init  (div_rem_init),
      .feed_init (div_feed_init),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (div_quotient)
   );

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_ACC_XY: begin
            mul_a = signed'(MUL_A_W'(xv_ff));
            mul_b = signed'(MUL_B_W'(yv_ff));
         end
         ST_ACC_XX: begin
            mul_a = signed'(MUL_A_W'(xv_ff));
            mul_b = signed'(MUL_B_W'(xv_ff));
         end
         ST_FIT_NXX: begin
            mul_a = signed'(MUL_A_W'(sum_square_ff));
            mul_b = signed'(MUL_B_W'(run_count_ff));
         end
         ST_FIT_XX: begin
            mul_a = signed'(MUL_A_W'(sum_first_ff));
            mul_b = signed'(MUL_B_W'(sum_first_ff));
         end
         ST_FIT_NXY: begin
            mul_a = signed'(MUL_A_W'(sum_product_ff));
            mul_b = signed'(MUL_B_W'(run_count_ff));
         end
         ST_FIT_XY: begin
            mul_a = signed'(MUL_A_W'(sum_first_ff));
            mul_b = signed'(MUL_B_W'(sum_second_ff));
         end
         ST_MUL_T: begin
            mul_a = MUL_A_W'(slope_u_ff);
            mul_b = signed'(MUL_B_W'(sum_first_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in       = state_ff;
      mode_in        = csr_wr_en ? csr_wr_data : mode_ff;
      run_count_in   = run_count_ff;
      sum_first_in   = sum_first_ff;
      sum_second_in  = sum_second_ff;
      sum_product_in = sum_product_ff;
      sum_square_in  = sum_square_ff;
      drop_in        = drop_ff;
      xv_in          = xv_ff;
      yv_in          = yv_ff;
      last_in        = last_ff;
      nxx_in         = nxx_ff;
      den_in         = den_ff;
      nxy_in         = nxy_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      slope_u_in     = slope_u_ff;
      t_in           = t_ff;
      icpt_in        = icpt_ff;
      degen_in       = degen_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_slope_in   = rsp_slope_ff;
      rsp_icpt_in    = rsp_icpt_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_degen_in   = rsp_degen_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      div_ctrl       = '0;
      div_rem_init   = '0;
      div_feed_init  = '0;
      div_divisor    = den_ff;
      load_rsp       = 1'b0;
      accept         = 1'b0;
      prod_low       = prod[DEN_W-1:0];
      abs_t          = t_ff[T_W-1] ? unsigned'(-t_ff) : unsigned'(t_ff);
      vert_slope     = (slope_u_ff == S_MIN) ? S_MAX : -slope_u_ff;
      req_ready      = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               accept  = 1'b1;
               xv_in   = mode_ff ? req_coord_y : req_coord_x;
               yv_in   = mode_ff ? req_coord_x : req_coord_y;
               last_in = req_last_point;
               if (run_count_ff < COUNT_W'(MAX_POINTS)) begin
                  run_count_in  = run_count_ff + COUNT_W'(1);
                  sum_first_in  = sum_first_ff + SUM1_W'(xv_in);
                  sum_second_in = sum_second_ff + SUM1_W'(yv_in);
                  state_in      = ST_ACC_XY;
               end else begin
                  // run full: point is dropped, a last point still closes the run
                  drop_in  = 1'b1;
                  state_in = req_last_point ? ST_FIT_NXX : ST_IDLE;
               end
            end
         end
         ST_ACC_XY: begin
            state_in = ST_ACC_XX;
         end
         ST_ACC_XX: begin
            sum_product_in = sum_product_ff + SUM2_W'(prod);
            state_in       = ST_ACC_END;
         end
         ST_ACC_END: begin
            sum_square_in = sum_square_ff + SUM2_W'(prod);
            state_in      = last_ff ? ST_FIT_NXX : ST_IDLE;
         end
         ST_FIT_NXX: begin
            state_in = ST_FIT_XX;
         end
         ST_FIT_XX: begin
            nxx_in   = prod_low;
            state_in = ST_FIT_NXY;
         end
         ST_FIT_NXY: begin
            den_in   = (nxx_ff > prod_low) ? (nxx_ff - prod_low) : '0;
            state_in = ST_FIT_XY;
         end
         ST_FIT_XY: begin
            nxy_in   = prod_low;
            state_in = ST_FIT_MAG;
         end
         ST_FIT_MAG: begin
            neg_in   = (nxy_ff < prod_low);
            mag_in   = (nxy_ff < prod_low) ? (prod_low - nxy_ff) : (nxy_ff - prod_low);
            state_in = ST_FIT_CHK;
         end
         ST_FIT_CHK: begin
            if (den_ff == '0 || run_count_ff == '0) begin
               degen_in   = 1'b1;
               slope_u_in = '0;
               icpt_in    = '0;
               state_in   = ST_DONE;
            end else if ((mag_ff >> FRAC_W) >= den_ff) begin
               // integer part of the slope too large: capped magnitude
               slope_u_in = sat_mag(neg_ff, FEED_W'(1) << OUT_W);
               state_in   = ST_MUL_T;
            end else begin
               div_ctrl.start = 1'b1;
               div_ctrl.steps = STEP_W'(OUT_W);
               div_rem_init   = mag_ff >> FRAC_W;
               div_feed_init  = {mag_ff[FRAC_W-1:0], {(FEED_W-FRAC_W){1'b0}}};
               div_divisor    = den_ff;
               state_in       = ST_DIV_SLOPE;
            end
         end
         ST_DIV_SLOPE: begin
            if (div_stat.done) begin
               slope_u_in = sat_mag(neg_ff, FEED_W'(div_quotient[OUT_W-1:0]));
               state_in   = ST_MUL_T;
            end
         end
         ST_MUL_T: begin
            state_in = ST_FIT_T;
         end
         ST_FIT_T: begin
            t_in     = signed'(T_W'({sum_second_ff, {FRAC_W{1'b0}}})) - T_W'(prod);
            state_in = ST_ICPT_GO;
         end
         ST_ICPT_GO: begin
            // truncating t / (n << 16) equals truncating (|t| >> 16) / n
            div_ctrl.start = 1'b1;
            div_ctrl.steps = STEP_W'(FEED_W);
            div_rem_init   = '0;
            div_feed_init  = FEED_W'(abs_t >> FRAC_W);
            div_divisor    = DEN_W'(run_count_ff);
            state_in       = ST_DIV_ICPT;
         end
         ST_DIV_ICPT: begin
            if (div_stat.done) begin
               icpt_in  = sat_mag(t_ff[T_W-1], div_quotient);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp       = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_slope_in   = mode_ff ? vert_slope : slope_u_ff;
               rsp_icpt_in    = icpt_ff;
               rsp_count_in   = POINT_CNT_W'(run_count_ff);
               rsp_degen_in   = degen_ff;
               rsp_ovf_in     = drop_ff;
               run_count_in   = '0;
               sum_first_in   = '0;
               sum_second_in  = '0;
               sum_product_in = '0;
               sum_square_in  = '0;
               drop_in        = 1'b0;
               degen_in       = 1'b0;
               state_in       = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         mode_ff        <= 1'b0;
         run_count_ff   <= '0;
         sum_first_ff   <= '0;
         sum_second_ff  <= '0;
         sum_product_ff <= '0;
         sum_square_ff  <= '0;
         drop_ff        <= 1'b0;
         degen_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         mode_ff        <= mode_in;
         run_count_ff   <= run_count_in;
         sum_first_ff   <= sum_first_in;
         sum_second_ff  <= sum_second_in;
         sum_product_ff <= sum_product_in;
         sum_square_ff  <= sum_square_in;
         drop_ff        <= drop_in;
         degen_ff       <= degen_in;
         rsp_valid_ff   <= rsp_valid_in;
         xv_ff          <= xv_in;
         yv_ff          <= yv_in;
         last_ff        <= last_in;
         nxx_ff         <= nxx_in;
         den_ff         <= den_in;
         nxy_ff         <= nxy_in;
         neg_ff         <= neg_in;
         mag_ff         <= mag_in;
         slope_u_ff     <= slope_u_in;
         t_ff           <= t_in;
         icpt_ff        <= icpt_in;
         rsp_slope_ff   <= rsp_slope_in;
         rsp_icpt_ff    <= rsp_icpt_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_degen_ff   <= rsp_degen_in;
         rsp_ovf_ff     <= rsp_ovf_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slope       = rsp_slope_ff;
   assign rsp_intercept   = rsp_icpt_ff;
   assign rsp_point_count = rsp_count_ff;
   assign rsp_degenerate  = rsp_degen_ff;
   assign rsp_overflowed  = rsp_ovf_ff;

   // a degenerate fit reports zero slope and intercept
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_degen_ff |-> (rsp_slope_ff == '0 && rsp_icpt_ff == '0))
      else $error("degenerate result with nonzero outputs");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      run_count_ff <= COUNT_W'(MAX_POINTS))
      else $error("point count beyond capacity");

   // the divider is never restarted while a division is in flight
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_stat.busy)
      else $error("divider started while busy");

   // a result transfer into the output register leaves an empty run behind
   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (run_count_ff == '0 && !drop_ff && rsp_valid_ff))
      else $error("run not cleared after result");

   // a point that is folded in, or that closes the run, holds off the next one
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (run_count_ff < COUNT_W'(MAX_POINTS) || req_last_point) |=> !req_ready)
      else $error("point accepted again before the previous one was folded in");

endmodule
`default_nettype wire

### hdl/lslf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lslf_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module lslf_mul
   import lslf_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic signed [MUL_A_W-1:0]  mul_a,
   input  wire logic signed [MUL_B_W-1:0]  mul_b,
   output logic signed      [PROD_W-1:0]   prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

### hdl/lslf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lslf_div
// Restoring divider, one quotient bit per cycle, shared by slope and intercept.
// ---------------------------------------------------------------------------
module lslf_div
   import lslf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire div_ctrl_type       ctrl,
   input  wire logic [DEN_W-1:0]   rem_init,
   input  wire logic [FEED_W-1:0]  feed_init,
   input  wire logic [DEN_W-1:0]   divisor,
   output div_stat_type            stat,
   output logic [FEED_W-1:0]       quotient
);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [FEED_W-1:0] feed_ff, feed_in;
   logic [FEED_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, feed_ff[FEED_W-1]};
      diff    = trial - {1'b0, div_ff};
      ge      = (trial >= {1'b0, div_ff});
      rem_in  = rem_ff;
      feed_in = feed_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = rem_init;
         feed_in = feed_init;
         quo_in  = '0;
         div_in  = divisor;
         cnt_in  = ctrl.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so the low bits suffice
         rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         feed_in = {feed_ff[FEED_W-2:0], 1'b0};
         quo_in  = {quo_ff[FEED_W-2:0], ge};
         cnt_in  = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         rem_ff  <= rem_in;
         feed_ff <= feed_in;
         quo_ff  <= quo_in;
         div_ff  <= div_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
`default_nettype wire
